@@ sv/rftm_pkg.sv @@
// shared constants and types for the floor texel mapper
`timescale 1ns / 1ps

package rftm_pkg;

    // default geometry
    localparam int MAP_BITS_DEF    = 6;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int SCREEN_BITS_DEF = 11;

    // fixed field widths
    localparam int WALL_FRAC_W = 16;
    localparam int WALL_DIST_W = 24;
    localparam int CAM_W       = 22;
    localparam int TEX_W       = 10;
    localparam int TEX_LOG_W   = 4;

    localparam logic [TEX_LOG_W-1:0] TEX_LOG_MAX = 4'd10;
    localparam logic [TEX_LOG_W-1:0] TEX_LOG_RST = 4'd6;
    localparam int                   SCREEN_HEIGHT_RST = 480;

    typedef enum logic [0:0] {
        CFG_SCREEN_HEIGHT = 1'b0,
        CFG_TEX_LOG2      = 1'b1
    } cfg_reg_t;

endpackage

@@ sv/rftm_front.sv @@
// front stage: draw window, wall foot point and divisor product
`timescale 1ns / 1ps

module rftm_front #(
    parameter int MAP_BITS    = rftm_pkg::MAP_BITS_DEF,
    parameter int FRAC_BITS   = rftm_pkg::FRAC_BITS_DEF,
    parameter int SCREEN_BITS = rftm_pkg::SCREEN_BITS_DEF,
    localparam int H_W   = SCREEN_BITS + 1,
    localparam int PT_W  = MAP_BITS + 1 + FRAC_BITS,
    localparam int DEN_W = H_W + rftm_pkg::WALL_DIST_W
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [SCREEN_BITS-1:0]               column,
    input  logic [SCREEN_BITS-1:0]               row,
    input  logic [MAP_BITS-1:0]                  map_x,
    input  logic [MAP_BITS-1:0]                  map_y,
    input  logic [rftm_pkg::WALL_FRAC_W-1:0]     wall_frac,
    input  logic                                 hit_side,
    input  logic                                 dir_x_positive,
    input  logic                                 dir_y_positive,
    input  logic [rftm_pkg::WALL_DIST_W-1:0]     wall_distance,
    input  logic [rftm_pkg::CAM_W-1:0]           cam_x,
    input  logic [rftm_pkg::CAM_W-1:0]           cam_y,
    input  logic [SCREEN_BITS-1:0]               wall_bottom,
    input  logic [H_W-1:0]                       screen_height,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [SCREEN_BITS-1:0]               out_column,
    output logic [SCREEN_BITS-1:0]               out_row,
    output logic                                 out_draw,
    output logic                                 out_wd_zero,
    output logic [H_W-1:0]                       out_height,
    output logic [DEN_W-1:0]                     out_den,
    output logic [PT_W-1:0]                      out_wx,
    output logic [PT_W-1:0]                      out_wy,
    output logic [rftm_pkg::CAM_W-1:0]           out_cx,
    output logic [rftm_pkg::CAM_W-1:0]           out_cy
);

    logic                          valid_reg;
    logic [SCREEN_BITS-1:0]        column_reg, row_reg;
    logic                          draw_reg, wd_zero_reg;
    logic [H_W-1:0]                height_reg;
    logic [DEN_W-1:0]              den_reg;
    logic [PT_W-1:0]               wx_reg, wy_reg;
    logic [rftm_pkg::CAM_W-1:0]    cx_reg, cy_reg;

    logic [SCREEN_BITS+1:0]        row_x2, row_ext, h_ext;
    logic                          draw_next;
    logic [H_W-1:0]                d;
    logic [DEN_W-1:0]              den_next;
    logic [FRAC_BITS-1:0]          fa;
    logic [MAP_BITS:0]             mx_ext, my_ext, mx_far, my_far;
    logic [PT_W-1:0]               base_x, base_y, far_x, far_y, face_x, face_y;
    logic [PT_W-1:0]               wx_next, wy_next;

    assign row_x2  = {1'b0, row, 1'b0};
    assign row_ext = {2'b00, row};
    assign h_ext   = {1'b0, screen_height};

    // below the wall, at least two rows above the screen bottom, and positive denominator
    assign draw_next = (row > wall_bottom)
                    && ((row_ext + (SCREEN_BITS+2)'(2)) <= h_ext)
                    && (row_x2 > h_ext);
    assign d        = H_W'(row_x2 - h_ext);
    assign den_next = DEN_W'(d) * DEN_W'(wall_distance);

    // wall_frac aligned to the fraction width
    assign fa = FRAC_BITS'({wall_frac, {FRAC_BITS{1'b0}}} >> rftm_pkg::WALL_FRAC_W);

    assign mx_ext = {1'b0, map_x};
    assign my_ext = {1'b0, map_y};
    assign mx_far = mx_ext + (MAP_BITS+1)'(1);
    assign my_far = my_ext + (MAP_BITS+1)'(1);
    assign base_x = {mx_ext, {FRAC_BITS{1'b0}}};
    assign base_y = {my_ext, {FRAC_BITS{1'b0}}};
    assign far_x  = {mx_far, {FRAC_BITS{1'b0}}};
    assign far_y  = {my_far, {FRAC_BITS{1'b0}}};
    assign face_x = {1'b0, map_x, fa};
    assign face_y = {1'b0, map_y, fa};

    // zero direction counts as negative: far side of the cell
    assign wx_next = hit_side ? face_x : (dir_x_positive ? base_x : far_x);
    assign wy_next = hit_side ? (dir_y_positive ? base_y : far_y) : face_y;

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            column_reg  <= column;
            row_reg     <= row;
            draw_reg    <= draw_next;
            wd_zero_reg <= (wall_distance == '0);
            height_reg  <= screen_height;
            den_reg     <= den_next;
            wx_reg      <= wx_next;
            wy_reg      <= wy_next;
            cx_reg      <= cam_x;
            cy_reg      <= cam_y;
        end
    end

    assign out_valid   = valid_reg;
    assign out_column  = column_reg;
    assign out_row     = row_reg;
    assign out_draw    = draw_reg;
    assign out_wd_zero = wd_zero_reg;
    assign out_height  = height_reg;
    assign out_den     = den_reg;
    assign out_wx      = wx_reg;
    assign out_wy      = wy_reg;
    assign out_cx      = cx_reg;
    assign out_cy      = cy_reg;

endmodule

@@ sv/rftm_div.sv @@
// pipelined restoring divider for the blend weight, one quotient bit per stage
`timescale 1ns / 1ps

module rftm_div #(
    parameter int FRAC_BITS = rftm_pkg::FRAC_BITS_DEF,
    parameter int H_W       = rftm_pkg::SCREEN_BITS_DEF + 1,
    parameter int DEN_W     = rftm_pkg::SCREEN_BITS_DEF + 1 + rftm_pkg::WALL_DIST_W,
    parameter int SIDE_W    = 8,
    localparam int NW = H_W + 2 * FRAC_BITS,
    localparam int CW = ((DEN_W + FRAC_BITS) > NW) ? (DEN_W + FRAC_BITS) : NW
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [H_W-1:0]       height,
    input  logic [DEN_W-1:0]     den,
    input  logic                 force_one,
    input  logic [SIDE_W-1:0]    side_in,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [FRAC_BITS:0]   weight,
    output logic [SIDE_W-1:0]    side_out
);

    logic                  valid_reg [0:FRAC_BITS];
    logic                  sat_reg   [0:FRAC_BITS];
    logic [NW-1:0]         rem_reg   [0:FRAC_BITS];
    logic [FRAC_BITS-1:0]  quo_reg   [0:FRAC_BITS];
    logic [DEN_W-1:0]      den_reg   [0:FRAC_BITS];
    logic [SIDE_W-1:0]     side_reg  [0:FRAC_BITS];
    logic                  rdy       [0:FRAC_BITS+1];

    logic [CW-1:0]         num_c, den_top;
    logic                  sat_next;

    assign rdy[FRAC_BITS+1] = out_ready;
    assign in_ready         = rdy[0];

    // quotient of 1.0 or more saturates
    assign num_c    = CW'({height, {(2*FRAC_BITS){1'b0}}});
    assign den_top  = CW'(den) << FRAC_BITS;
    assign sat_next = force_one || (num_c >= den_top);

    assign rdy[0] = !valid_reg[0] || rdy[1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg[0] <= 1'b0;
        end else if (rdy[0]) begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[0] && in_valid) begin
            sat_reg[0]  <= sat_next;
            rem_reg[0]  <= NW'(num_c);
            quo_reg[0]  <= '0;
            den_reg[0]  <= den;
            side_reg[0] <= side_in;
        end
    end

    for (genvar k = 1; k <= FRAC_BITS; k++) begin : g_stage
        localparam int BIT = FRAC_BITS - k;
        logic [CW-1:0]        trial;
        logic                 ge;
        logic [CW-1:0]        diff;
        logic [FRAC_BITS-1:0] bit_mask;

        assign trial    = CW'(den_reg[k-1]) << BIT;
        assign ge       = CW'(rem_reg[k-1]) >= trial;
        assign diff     = CW'(rem_reg[k-1]) - trial;
        assign bit_mask = FRAC_BITS'(1) << BIT;
        assign rdy[k]   = !valid_reg[k] || rdy[k+1];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (rdy[k]) begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (rdy[k] && valid_reg[k-1]) begin
                sat_reg[k]  <= sat_reg[k-1];
                rem_reg[k]  <= ge ? NW'(diff) : rem_reg[k-1];
                quo_reg[k]  <= ge ? (quo_reg[k-1] | bit_mask) : quo_reg[k-1];
                den_reg[k]  <= den_reg[k-1];
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign out_valid = valid_reg[FRAC_BITS];
    assign weight    = sat_reg[FRAC_BITS] ? ((FRAC_BITS+1)'(1) << FRAC_BITS)
                                          : {1'b0, quo_reg[FRAC_BITS]};
    assign side_out  = side_reg[FRAC_BITS];

endmodule

@@ sv/rftm_blend.sv @@
// blend of wall foot point and camera, cell and texel extraction
`timescale 1ns / 1ps

module rftm_blend #(
    parameter int MAP_BITS    = rftm_pkg::MAP_BITS_DEF,
    parameter int FRAC_BITS   = rftm_pkg::FRAC_BITS_DEF,
    parameter int SCREEN_BITS = rftm_pkg::SCREEN_BITS_DEF,
    localparam int PT_W = MAP_BITS + 1 + FRAC_BITS,
    localparam int PX_W = FRAC_BITS + 1 + PT_W,
    localparam int PC_W = FRAC_BITS + 1 + rftm_pkg::CAM_W,
    localparam int SW   = ((PX_W > PC_W) ? PX_W : PC_W) + 1,
    localparam int EXT_W = FRAC_BITS + rftm_pkg::TEX_W
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [FRAC_BITS:0]                  weight,
    input  logic [SCREEN_BITS-1:0]              column,
    input  logic [SCREEN_BITS-1:0]              row,
    input  logic                                draw,
    input  logic [PT_W-1:0]                     wx,
    input  logic [PT_W-1:0]                     wy,
    input  logic [rftm_pkg::CAM_W-1:0]          cx,
    input  logic [rftm_pkg::CAM_W-1:0]          cy,
    input  logic [rftm_pkg::TEX_LOG_W-1:0]      tex_log2,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [SCREEN_BITS-1:0]              out_column,
    output logic [SCREEN_BITS-1:0]              out_row,
    output logic                                out_draw,
    output logic [MAP_BITS-1:0]                 cell_x,
    output logic [MAP_BITS-1:0]                 cell_y,
    output logic [rftm_pkg::TEX_W-1:0]          tex_x,
    output logic [rftm_pkg::TEX_W-1:0]          tex_y
);

    // product stage
    logic                    p_valid_reg;
    logic [SCREEN_BITS-1:0]  p_column_reg, p_row_reg;
    logic                    p_draw_reg;
    logic [PX_W-1:0]         p_wx_reg, p_wy_reg;
    logic [PC_W-1:0]         p_cx_reg, p_cy_reg;
    logic [FRAC_BITS:0]      inv_w;
    logic                    p_ready;

    // output stage
    logic                          o_valid_reg;
    logic [SCREEN_BITS-1:0]        o_column_reg, o_row_reg;
    logic                          o_draw_reg;
    logic [MAP_BITS-1:0]           o_cell_x_reg, o_cell_y_reg;
    logic [rftm_pkg::TEX_W-1:0]    o_tex_x_reg, o_tex_y_reg;
    logic                          o_ready;

    logic [SW-1:0]                 sum_x, sum_y;
    logic [rftm_pkg::TEX_LOG_W-1:0] tlog;
    logic [5:0]                    tshift;
    logic [EXT_W-1:0]              ext_x, ext_y;
    logic [rftm_pkg::TEX_W-1:0]    tex_x_next, tex_y_next;

    assign inv_w = ((FRAC_BITS+1)'(1) << FRAC_BITS) - weight;

    assign o_ready  = !o_valid_reg || out_ready;
    assign p_ready  = !p_valid_reg || o_ready;
    assign in_ready = p_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
        end else if (p_ready) begin
            p_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (p_ready && in_valid) begin
            p_column_reg <= column;
            p_row_reg    <= row;
            p_draw_reg   <= draw;
            p_wx_reg     <= PX_W'(weight) * PX_W'(wx);
            p_wy_reg     <= PX_W'(weight) * PX_W'(wy);
            p_cx_reg     <= PC_W'(inv_w) * PC_W'(cx);
            p_cy_reg     <= PC_W'(inv_w) * PC_W'(cy);
        end
    end

    assign sum_x = SW'(p_wx_reg) + SW'(p_cx_reg);
    assign sum_y = SW'(p_wy_reg) + SW'(p_cy_reg);

    // texel = fraction scaled by 2^tlog, done as one right shift of a padded fraction
    assign tlog   = (tex_log2 > rftm_pkg::TEX_LOG_MAX) ? rftm_pkg::TEX_LOG_MAX : tex_log2;
    assign tshift = 6'(EXT_W) - 6'(tlog);
    assign ext_x  = {sum_x[FRAC_BITS +: FRAC_BITS], {rftm_pkg::TEX_W{1'b0}}} >> tshift;
    assign ext_y  = {sum_y[FRAC_BITS +: FRAC_BITS], {rftm_pkg::TEX_W{1'b0}}} >> tshift;
    assign tex_x_next = ext_x[rftm_pkg::TEX_W-1:0];
    assign tex_y_next = ext_y[rftm_pkg::TEX_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_valid_reg <= 1'b0;
        end else if (o_ready) begin
            o_valid_reg <= p_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (o_ready && p_valid_reg) begin
            o_column_reg <= p_column_reg;
            o_row_reg    <= p_row_reg;
            o_draw_reg   <= p_draw_reg;
            if (p_draw_reg) begin
                o_cell_x_reg <= sum_x[2*FRAC_BITS +: MAP_BITS];
                o_cell_y_reg <= sum_y[2*FRAC_BITS +: MAP_BITS];
                o_tex_x_reg  <= tex_x_next;
                o_tex_y_reg  <= tex_y_next;
            end else begin
                o_cell_x_reg <= '0;
                o_cell_y_reg <= '0;
                o_tex_x_reg  <= '0;
                o_tex_y_reg  <= '0;
            end
        end
    end

    assign out_valid  = o_valid_reg;
    assign out_column = o_column_reg;
    assign out_row    = o_row_reg;
    assign out_draw   = o_draw_reg;
    assign cell_x     = o_cell_x_reg;
    assign cell_y     = o_cell_y_reg;
    assign tex_x      = o_tex_x_reg;
    assign tex_y      = o_tex_y_reg;

endmodule

@@ sv/raycast_floor_texel_mapper.sv @@
// top level of the raycaster floor texel mapper
`timescale 1ns / 1ps

// Maps one floor pixel per clock unless m_ready stalls the pipe: each transfer on the
// s_ channel carries a column's wall-hit data and a row, and yields one m_ transfer
// with the floor map cell and the texel coordinates, draw low (and cell/texel zero)
// outside the floor span. Throughput is one item per cycle while m_ready is high. The
// weight divider resolves one quotient bit per pipeline stage; it sits between one
// front stage and two blend stages. Stages advance independently, so bubbles close up
// even while a result waits on m_ready. Configuration writes take effect at once and
// must be made by the user while no item is in flight; the block does not enforce it.

module raycast_floor_texel_mapper #(
    parameter int MAP_BITS    = rftm_pkg::MAP_BITS_DEF,
    parameter int FRAC_BITS   = rftm_pkg::FRAC_BITS_DEF,
    parameter int SCREEN_BITS = rftm_pkg::SCREEN_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration
    input  logic                               cfg_wr_en,
    input  logic [0:0]                         cfg_addr,
    input  logic [SCREEN_BITS:0]               cfg_wr_data,
    // input channel
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [SCREEN_BITS-1:0]             s_column,
    input  logic [SCREEN_BITS-1:0]             s_row,
    input  logic [MAP_BITS-1:0]                s_map_x,
    input  logic [MAP_BITS-1:0]                s_map_y,
    input  logic [rftm_pkg::WALL_FRAC_W-1:0]   s_wall_frac,
    input  logic                               s_hit_side,
    input  logic                               s_dir_x_positive,
    input  logic                               s_dir_y_positive,
    input  logic [rftm_pkg::WALL_DIST_W-1:0]   s_wall_distance,
    input  logic [rftm_pkg::CAM_W-1:0]         s_cam_x,
    input  logic [rftm_pkg::CAM_W-1:0]         s_cam_y,
    input  logic [SCREEN_BITS-1:0]             s_wall_bottom,
    // result channel
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [SCREEN_BITS-1:0]             m_out_column,
    output logic [SCREEN_BITS-1:0]             m_out_row,
    output logic                               m_draw,
    output logic [MAP_BITS-1:0]                m_cell_x,
    output logic [MAP_BITS-1:0]                m_cell_y,
    output logic [rftm_pkg::TEX_W-1:0]         m_tex_x,
    output logic [rftm_pkg::TEX_W-1:0]         m_tex_y
);

    localparam int H_W    = SCREEN_BITS + 1;
    localparam int PT_W   = MAP_BITS + 1 + FRAC_BITS;
    localparam int DEN_W  = H_W + rftm_pkg::WALL_DIST_W;
    localparam int SIDE_W = 2 * SCREEN_BITS + 1 + 2 * PT_W + 2 * rftm_pkg::CAM_W;

    logic [H_W-1:0]                     screen_height_reg;
    logic [rftm_pkg::TEX_LOG_W-1:0]     tex_log2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            screen_height_reg <= H_W'(rftm_pkg::SCREEN_HEIGHT_RST);
            tex_log2_reg      <= rftm_pkg::TEX_LOG_RST;
        end else if (cfg_wr_en) begin
            unique case (rftm_pkg::cfg_reg_t'(cfg_addr))
                rftm_pkg::CFG_SCREEN_HEIGHT: screen_height_reg <= cfg_wr_data;
                rftm_pkg::CFG_TEX_LOG2:      tex_log2_reg <= cfg_wr_data[rftm_pkg::TEX_LOG_W-1:0];
                default: ;
            endcase
        end
    end

    // front to divider
    logic                          f_valid, f_ready;
    logic [SCREEN_BITS-1:0]        f_column, f_row;
    logic                          f_draw, f_wd_zero;
    logic [H_W-1:0]                f_height;
    logic [DEN_W-1:0]              f_den;
    logic [PT_W-1:0]               f_wx, f_wy;
    logic [rftm_pkg::CAM_W-1:0]    f_cx, f_cy;
    logic [SIDE_W-1:0]             f_side;

    // divider to blend
    logic                          d_valid, d_ready;
    logic [FRAC_BITS:0]            d_weight;
    logic [SIDE_W-1:0]             d_side;
    logic [SCREEN_BITS-1:0]        d_column, d_row;
    logic                          d_draw;
    logic [PT_W-1:0]               d_wx, d_wy;
    logic [rftm_pkg::CAM_W-1:0]    d_cx, d_cy;

    rftm_front #(
        .MAP_BITS    (MAP_BITS),
        .FRAC_BITS   (FRAC_BITS),
        .SCREEN_BITS (SCREEN_BITS)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (s_valid),
        .in_ready       (s_ready),
        .column         (s_column),
        .row            (s_row),
        .map_x          (s_map_x),
        .map_y          (s_map_y),
        .wall_frac      (s_wall_frac),
        .hit_side       (s_hit_side),
        .dir_x_positive (s_dir_x_positive),
        .dir_y_positive (s_dir_y_positive),
        .wall_distance  (s_wall_distance),
        .cam_x          (s_cam_x),
        .cam_y          (s_cam_y),
        .wall_bottom    (s_wall_bottom),
        .screen_height  (screen_height_reg),
        .out_valid      (f_valid),
        .out_ready      (f_ready),
        .out_column     (f_column),
        .out_row        (f_row),
        .out_draw       (f_draw),
        .out_wd_zero    (f_wd_zero),
        .out_height     (f_height),
        .out_den        (f_den),
        .out_wx         (f_wx),
        .out_wy         (f_wy),
        .out_cx         (f_cx),
        .out_cy         (f_cy)
    );

    assign f_side = {f_column, f_row, f_draw, f_wx, f_wy, f_cx, f_cy};

    rftm_div #(
        .FRAC_BITS (FRAC_BITS),
        .H_W       (H_W),
        .DEN_W     (DEN_W),
        .SIDE_W    (SIDE_W)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .height    (f_height),
        .den       (f_den),
        .force_one (f_wd_zero),
        .side_in   (f_side),
        .out_valid (d_valid),
        .out_ready (d_ready),
        .weight    (d_weight),
        .side_out  (d_side)
    );

    assign {d_column, d_row, d_draw, d_wx, d_wy, d_cx, d_cy} = d_side;

    rftm_blend #(
        .MAP_BITS    (MAP_BITS),
        .FRAC_BITS   (FRAC_BITS),
        .SCREEN_BITS (SCREEN_BITS)
    ) u_blend (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (d_valid),
        .in_ready   (d_ready),
        .weight     (d_weight),
        .column     (d_column),
        .row        (d_row),
        .draw       (d_draw),
        .wx         (d_wx),
        .wy         (d_wy),
        .cx         (d_cx),
        .cy         (d_cy),
        .tex_log2   (tex_log2_reg),
        .out_valid  (m_valid),
        .out_ready  (m_ready),
        .out_column (m_out_column),
        .out_row    (m_out_row),
        .out_draw   (m_draw),
        .cell_x     (m_cell_x),
        .cell_y     (m_cell_y),
        .tex_x      (m_tex_x),
        .tex_y      (m_tex_y)
    );

endmodule
